// ===== rtl/fmt_pkg.sv =====
// ----------------------------------------------------------------------------
// fmt_pkg
// Shared types and constants for the FASTA melting temperature block.
// ----------------------------------------------------------------------------
package fmt_pkg;

    // Base counters
    localparam int CNT_W   = 24;
    localparam int THR_W   = 8;
    localparam int TEMP_W  = 15;

    // Scaled operands: 10 * count needs four more bits
    localparam int W10     = CNT_W + 4;
    localparam int SLOPE_W = 14;
    localparam int W_NUM   = W10 + SLOPE_W;
    // Quotient magnitude stays below 2^18 (worst case 10496*164/10)
    localparam int Q_W     = 18;
    localparam int W_DIV   = W10 + Q_W - 1;
    localparam int QC_W    = $clog2(Q_W);

    // Record queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QA_W    = $clog2(QDEPTH);
    localparam int QN_W    = $clog2(QDEPTH + 1);

    localparam logic [CNT_W-1:0]   CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [TEMP_W-1:0]  TEMP_MAX = {TEMP_W{1'b1}};
    localparam logic [Q_W-1:0]     BASE_Q8  = Q_W'(16614);
    localparam logic [SLOPE_W-1:0] SLOPE_Q8 = SLOPE_W'(10496);
    localparam logic [W10-1:0]     OFFSET_TENTHS = W10'(164);
    localparam logic [THR_W-1:0]   THR_RESET = THR_W'(15);

    // Characters
    localparam logic [7:0] CH_HDR = 8'h3E;  // '>'
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_LC  = 8'h20;  // case bit
    localparam logic [7:0] CH_A   = 8'h61;
    localparam logic [7:0] CH_C   = 8'h63;
    localparam logic [7:0] CH_G   = 8'h67;
    localparam logic [7:0] CH_T   = 8'h74;

    // Register map
    localparam logic [2:0] ADDR_THR = 3'd0;

    typedef struct packed {
        logic [CNT_W-1:0] gc;
        logic [CNT_W-1:0] len;
    } t_rec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/fmt_front.sv =====
// ----------------------------------------------------------------------------
// fmt_front
// Byte classifier: tracks header lines, counts GC and AT bases and pushes
// one record per flush into the record queue.
// ----------------------------------------------------------------------------
module fmt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_text_byte,
    input  logic                i_end_of_input,
    input  logic                i_full,
    output logic                o_stall,
    output logic                o_push,
    output fmt_pkg::t_rec       o_rec
);

    logic                     r_hdr;
    logic [fmt_pkg::CNT_W-1:0] r_gc;
    logic [fmt_pkg::CNT_W-1:0] r_at;
    logic                     n_hdr;
    logic [fmt_pkg::CNT_W-1:0] n_gc;
    logic [fmt_pkg::CNT_W-1:0] n_at;

    logic                     accept;
    logic                     is_bracket;
    logic [7:0]               lc;
    logic [fmt_pkg::CNT_W-1:0] fl_gc;
    logic [fmt_pkg::CNT_W-1:0] fl_at;
    logic [fmt_pkg::CNT_W:0]   sum;
    logic                     do_flush;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign lc      = i_text_byte | fmt_pkg::CH_LC;
    assign is_bracket = !r_hdr && (i_text_byte == fmt_pkg::CH_HDR);

    always_comb begin
        n_hdr = r_hdr;
        n_gc  = r_gc;
        n_at  = r_at;
        if (r_hdr) begin
            if (i_text_byte == fmt_pkg::CH_NL) begin
                n_hdr = 1'b0;
            end
        end else if (is_bracket) begin
            n_hdr = 1'b1;
            n_gc  = '0;
            n_at  = '0;
        end else if (lc == fmt_pkg::CH_G || lc == fmt_pkg::CH_C) begin
            n_gc = (r_gc == fmt_pkg::CNT_MAX) ? r_gc : r_gc + 1'b1;
        end else if (lc == fmt_pkg::CH_A || lc == fmt_pkg::CH_T) begin
            n_at = (r_at == fmt_pkg::CNT_MAX) ? r_at : r_at + 1'b1;
        end

        // A bracket flushes the old counts; end of input flushes the updated ones
        fl_gc = is_bracket ? r_gc : n_gc;
        fl_at = is_bracket ? r_at : n_at;
        do_flush = accept && (is_bracket || i_end_of_input) && (|fl_gc || |fl_at);

        if (i_end_of_input) begin
            n_hdr = 1'b0;
            n_gc  = '0;
            n_at  = '0;
        end
    end

    assign sum       = {1'b0, fl_gc} + {1'b0, fl_at};
    assign o_push    = do_flush;
    assign o_rec.gc  = fl_gc;
    assign o_rec.len = sum[fmt_pkg::CNT_W] ? fmt_pkg::CNT_MAX : sum[fmt_pkg::CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= 1'b0;
            r_gc  <= '0;
            r_at  <= '0;
        end else if (accept) begin
            r_hdr <= n_hdr;
            r_gc  <= n_gc;
            r_at  <= n_at;
        end
    end

endmodule

// ===== rtl/fmt_queue.sv =====
// ----------------------------------------------------------------------------
// fmt_queue
// Small record FIFO between the byte classifier and the temperature engine.
// ----------------------------------------------------------------------------
module fmt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fmt_pkg::t_rec i_rec,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output fmt_pkg::t_rec o_rec
);

    fmt_pkg::t_rec             r_mem [fmt_pkg::QDEPTH];
    logic [fmt_pkg::QA_W-1:0]  r_wp;
    logic [fmt_pkg::QA_W-1:0]  r_rp;
    logic [fmt_pkg::QN_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == fmt_pkg::QN_W'(fmt_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/fmt_back.sv =====
// ----------------------------------------------------------------------------
// fmt_back
// Temperature engine: Wallace rule in one step, or the GC-fraction rule
// through a scale stage, a multiply stage and a bit-serial divider.
// ----------------------------------------------------------------------------
module fmt_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  fmt_pkg::t_rec              i_rec,
    input  logic [fmt_pkg::THR_W-1:0]  i_thr,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [fmt_pkg::TEMP_W-1:0] o_melt_temp_q8,
    output logic [fmt_pkg::CNT_W-1:0]  o_record_length,
    output logic [fmt_pkg::CNT_W-1:0]  o_record_gc,
    output logic                       o_used_long_rule
);

    fmt_pkg::t_state r_state;
    fmt_pkg::t_state n_state;

    logic [fmt_pkg::CNT_W-1:0]  r_gc;
    logic [fmt_pkg::CNT_W-1:0]  r_len;
    logic                       r_long;
    logic [fmt_pkg::TEMP_W-1:0] r_short;
    logic [fmt_pkg::W10-1:0]    r_mag;
    logic                       r_neg;
    logic [fmt_pkg::W10-1:0]    r_den;
    logic [fmt_pkg::W_DIV-1:0]  r_rem;
    logic [fmt_pkg::W_DIV-1:0]  r_dsh;
    logic [fmt_pkg::Q_W-1:0]    r_q;
    logic [fmt_pkg::QC_W-1:0]   r_cnt;
    logic                       r_valid;
    logic [fmt_pkg::TEMP_W-1:0] r_temp;
    logic [fmt_pkg::CNT_W-1:0]  r_olen;
    logic [fmt_pkg::CNT_W-1:0]  r_ogc;
    logic                       r_olong;

    logic                       slot_free;
    logic                       use_long;
    logic [fmt_pkg::CNT_W+1:0]  sum2;
    logic [fmt_pkg::W10-1:0]    gc10;
    logic [fmt_pkg::W_NUM-1:0]  prod;
    logic                       ge;
    logic [fmt_pkg::Q_W:0]      pos_sum;
    logic [fmt_pkg::TEMP_W-1:0] long_temp;

    assign slot_free = !r_valid || !i_stall;
    assign use_long  = i_rec.len >= fmt_pkg::CNT_W'(i_thr);
    assign sum2      = (fmt_pkg::CNT_W+2)'(i_rec.gc) + (fmt_pkg::CNT_W+2)'(i_rec.len);
    assign gc10      = (fmt_pkg::W10'(r_gc) << 3) + (fmt_pkg::W10'(r_gc) << 1);
    assign prod      = fmt_pkg::W_NUM'(r_mag) * fmt_pkg::W_NUM'(fmt_pkg::SLOPE_Q8);
    assign ge        = r_rem >= r_dsh;
    assign pos_sum   = {1'b0, fmt_pkg::BASE_Q8} + {1'b0, r_q};

    always_comb begin
        if (r_neg) begin
            long_temp = (r_q > fmt_pkg::BASE_Q8) ? '0
                      : fmt_pkg::TEMP_W'(fmt_pkg::BASE_Q8 - r_q);
        end else begin
            long_temp = (pos_sum > (fmt_pkg::Q_W+1)'(fmt_pkg::TEMP_MAX)) ? fmt_pkg::TEMP_MAX
                      : pos_sum[fmt_pkg::TEMP_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            fmt_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = use_long ? fmt_pkg::ST_SCALE : fmt_pkg::ST_OUT;
                end
            end
            fmt_pkg::ST_SCALE: n_state = fmt_pkg::ST_MUL;
            fmt_pkg::ST_MUL:   n_state = fmt_pkg::ST_DIV;
            fmt_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = fmt_pkg::ST_OUT;
                end
            end
            fmt_pkg::ST_OUT: begin
                if (slot_free) begin
                    n_state = fmt_pkg::ST_IDLE;
                end
            end
            default: n_state = fmt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fmt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            fmt_pkg::ST_IDLE: begin
                if (o_pop) begin
                    r_gc    <= i_rec.gc;
                    r_len   <= i_rec.len;
                    r_long  <= use_long;
                    // (4*GC + 2*AT) = 2*(GC + len), times 256, saturated
                    r_short <= (sum2 >= (fmt_pkg::CNT_W+2)'(64)) ? fmt_pkg::TEMP_MAX
                             : {sum2[5:0], 9'h000};
                end
            end
            fmt_pkg::ST_SCALE: begin
                r_neg <= gc10 < fmt_pkg::OFFSET_TENTHS;
                r_mag <= (gc10 < fmt_pkg::OFFSET_TENTHS) ? fmt_pkg::OFFSET_TENTHS - gc10
                                                        : gc10 - fmt_pkg::OFFSET_TENTHS;
                r_den <= (fmt_pkg::W10'(r_len) << 3) + (fmt_pkg::W10'(r_len) << 1);
            end
            fmt_pkg::ST_MUL: begin
                r_rem <= fmt_pkg::W_DIV'(prod);
                r_dsh <= fmt_pkg::W_DIV'(r_den) << (fmt_pkg::Q_W - 1);
                r_q   <= '0;
                r_cnt <= fmt_pkg::QC_W'(fmt_pkg::Q_W - 1);
            end
            fmt_pkg::ST_DIV: begin
                // One quotient bit per cycle, divisor shifting down
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[fmt_pkg::Q_W-2:0], ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (r_state == fmt_pkg::ST_OUT && slot_free) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == fmt_pkg::ST_OUT && slot_free) begin
            r_temp  <= r_long ? long_temp : r_short;
            r_olen  <= r_len;
            r_ogc   <= r_gc;
            r_olong <= r_long;
        end
    end

    assign o_valid          = r_valid;
    assign o_melt_temp_q8   = r_temp;
    assign o_record_length  = r_olen;
    assign o_record_gc      = r_ogc;
    assign o_used_long_rule = r_olong;

endmodule

// ===== rtl/fasta_melting_temperature.sv =====
// ----------------------------------------------------------------------------
// fasta_melting_temperature
// Melting temperature of FASTA records in Q8, from a stream of text bytes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// in        sink       i_in_valid / o_in_stall  i_text_byte, i_end_of_input
// out       source     o_out_valid / i_out_stall o_melt_temp_q8, o_record_length,
//                                               o_record_gc, o_used_long_rule
// cfg       APB slave  psel/penable/pready      paddr, pwdata, prdata
//
// The classifier takes one byte per cycle; it stalls whenever the
// two-entry record queue is full.
// Per record the engine applies the Wallace rule or the GC-fraction rule
// (scale, multiply, 18-step divider, output load).
// Reset is synchronous and active low; the threshold resets to 15.
// A stalled output holds its beat while the classifier keeps counting until the record queue is full.
// ----------------------------------------------------------------------------
module fasta_melting_temperature (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_text_byte,
    input  logic                       i_end_of_input,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [fmt_pkg::TEMP_W-1:0] o_melt_temp_q8,
    output logic [fmt_pkg::CNT_W-1:0]  o_record_length,
    output logic [fmt_pkg::CNT_W-1:0]  o_record_gc,
    output logic                       o_used_long_rule,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [fmt_pkg::THR_W-1:0] r_thr;
    logic                      push;
    logic                      pop;
    logic                      full;
    logic                      empty;
    fmt_pkg::t_rec             push_rec;
    fmt_pkg::t_rec             pop_rec;

    assign pready = 1'b1;
    assign prdata = (paddr == fmt_pkg::ADDR_THR) ? 32'(r_thr) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= fmt_pkg::THR_RESET;
        end else if (psel && penable && pwrite && paddr == fmt_pkg::ADDR_THR) begin
            r_thr <= pwdata[fmt_pkg::THR_W-1:0];
        end
    end

    fmt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .i_text_byte    (i_text_byte),
        .i_end_of_input (i_end_of_input),
        .i_full         (full),
        .o_stall        (o_in_stall),
        .o_push         (push),
        .o_rec          (push_rec)
    );

    fmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_rec   (pop_rec)
    );

    fmt_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_rec            (pop_rec),
        .i_thr            (r_thr),
        .o_pop            (pop),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_melt_temp_q8   (o_melt_temp_q8),
        .o_record_length  (o_record_length),
        .o_record_gc      (o_record_gc),
        .o_used_long_rule (o_used_long_rule)
    );

endmodule
